// ===== rtl/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared constants and types for the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int RamDepthDefault = 256;

  // config register indexes
  localparam logic [1:0] CFG_ROM_SIZE = 2'd0;
  localparam logic [1:0] CFG_RAM_MODE = 2'd1;

  // image size codes
  localparam logic [1:0] ROM_2K  = 2'd0;
  localparam logic [1:0] ROM_4K  = 2'd1;
  localparam logic [1:0] ROM_F8  = 2'd2;
  localparam logic [1:0] ROM_F6  = 2'd3;

  // extra RAM modes
  localparam logic [1:0] RAM_NONE = 2'd0;
  localparam logic [1:0] RAM_128  = 2'd1;
  localparam logic [1:0] RAM_256  = 2'd2;

  // window offsets
  localparam logic [11:0] MIRROR_BASE = 12'h800;
  localparam logic [11:0] HOT_F6_LO   = 12'hFF6;
  localparam logic [11:0] HOT_F8_B0   = 12'hFF8;
  localparam logic [11:0] HOT_F8_B1   = 12'hFF9;
  localparam logic [11:0] SPAN_128    = 12'h080;
  localparam logic [11:0] SPAN_256    = 12'h100;

  // decoded bus access
  typedef struct packed {
    logic [1:0]  bank_next;
    logic [1:0]  eff_bank;
    logic [13:0] rom_offset;
    logic        ram_wr;
    logic        ram_rd;
    logic [7:0]  ram_byte;
  } cbm_access_t;

  // request into the RAM block
  typedef struct packed {
    logic       wr;
    logic       rd;
    logic [7:0] byte_addr;
    logic [7:0] wdata;
  } cbm_ram_req_t;

endpackage

// ===== rtl/cartridge_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// F8/F6 bank switching mapper for a 4K window with optional extra RAM.
// ----------------------------------------------------------------------------
// The result is registered and valid in the cycle after the access is accepted.
// Throughput: one access per cycle unless stalled or sweeping; RAM read data
// comes off the single registered read port of the RAM array; writes land at
// accept. Reset: config returns to 4K image / no RAM, bank 0; the RAM is then
// zeroed by a sweep of all RAM_DEPTH entries during which in_ready stays low.
module cartridge_bank_mapper import cbm_pkg::*; #(
  parameter int RAM_DEPTH = RamDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  // access channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [11:0] address,
  input  logic [7:0]  write_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] rom_offset,
  output logic        from_ram,
  output logic [7:0]  ram_data,
  output logic        ram_written,
  output logic [1:0]  active_bank
);

  logic [1:0]   rom_size_code;
  logic [1:0]   ram_mode;
  logic [1:0]   bank_select;
  cbm_access_t  acc;
  cbm_ram_req_t ram_req;
  logic [7:0]   ram_rd_data;
  logic         ram_busy;
  logic         in_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_size_code <= ROM_4K;
      ram_mode      <= RAM_NONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROM_SIZE: rom_size_code <= cfg_data;
        CFG_RAM_MODE: ram_mode      <= cfg_data;
        default: ;
      endcase
    end
  end

  cbm_decode u_decode (
    .rom_size_code (rom_size_code),
    .ram_mode      (ram_mode),
    .bank_select   (bank_select),
    .func          (func),
    .address       (address),
    .acc           (acc)
  );

  assign in_ready = !ram_busy && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    ram_req.wr        = in_fire && acc.ram_wr;
    ram_req.rd        = in_fire && acc.ram_rd;
    ram_req.byte_addr = acc.ram_byte;
    ram_req.wdata     = write_data;
  end

  cbm_ram #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .req     (ram_req),
    .rd_data (ram_rd_data),
    .busy    (ram_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select <= 2'd0;
      out_valid   <= 1'b0;
    end else begin
      if (in_fire) begin
        bank_select <= acc.bank_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rom_offset  <= acc.rom_offset;
      from_ram    <= acc.ram_rd;
      ram_written <= acc.ram_wr;
      active_bank <= acc.eff_bank;
    end
  end

  // read data register only moves on an accepted access, so it holds on stall
  assign ram_data = from_ram ? ram_rd_data : 8'd0;

endmodule

// ===== rtl/cbm_decode.sv =====
// ----------------------------------------------------------------------------
// cbm_decode
// Address fold, hotspot bank select and RAM port decode for one access.
// ----------------------------------------------------------------------------
module cbm_decode import cbm_pkg::*; (
  input  logic [1:0]  rom_size_code,
  input  logic [1:0]  ram_mode,
  input  logic [1:0]  bank_select,
  input  logic        func,
  input  logic [11:0] address,
  output cbm_access_t acc
);

  logic [11:0] a;
  logic [11:0] span;
  logic [11:0] rd_rel;
  logic [1:0]  bank_next;
  logic [1:0]  eff_bank;

  always_comb begin
    a = address;
    if (rom_size_code == ROM_2K && address >= MIRROR_BASE) begin
      a = address - MIRROR_BASE;
    end
  end

  // hotspots switch the bank before the access is served
  always_comb begin
    bank_next = bank_select;
    unique case (rom_size_code)
      ROM_F8: begin
        if (a == HOT_F8_B0) begin
          bank_next = 2'd0;
        end else if (a == HOT_F8_B1) begin
          bank_next = 2'd1;
        end
      end
      ROM_F6: begin
        if (a >= HOT_F6_LO && a <= HOT_F8_B1) begin
          bank_next = 2'(a - HOT_F6_LO);
        end
      end
      default: bank_next = bank_select;
    endcase
  end

  always_comb begin
    unique case (rom_size_code)
      ROM_F8:  eff_bank = {1'b0, bank_next[0]};
      ROM_F6:  eff_bank = bank_next;
      default: eff_bank = 2'd0;
    endcase
  end

  always_comb begin
    unique case (ram_mode)
      RAM_128: span = SPAN_128;
      RAM_256: span = SPAN_256;
      default: span = '0;
    endcase
  end

  assign rd_rel = a - span;

  always_comb begin
    acc.bank_next  = bank_next;
    acc.eff_bank   = eff_bank;
    acc.rom_offset = {eff_bank, a};
    acc.ram_wr     = (span != '0) && func && (a < span);
    acc.ram_rd     = (span != '0) && !func && (a >= span) && (rd_rel < span);
    acc.ram_byte   = func ? a[7:0] : rd_rel[7:0];
  end

endmodule

// ===== rtl/cbm_ram.sv =====
// ----------------------------------------------------------------------------
// cbm_ram
// Extra RAM store: one write and one registered read per cycle, zeroed by a
// sweep after reset.
// ----------------------------------------------------------------------------
module cbm_ram import cbm_pkg::*; #(
  parameter int RAM_DEPTH = RamDepthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  cbm_ram_req_t req,
  output logic [7:0]   rd_data,
  output logic         busy
);

  localparam int IdxW = $clog2(RAM_DEPTH);

  logic [7:0]      mem [RAM_DEPTH];
  logic [IdxW-1:0] clr_cnt;
  logic [IdxW-1:0] idx;
  logic [8:0]      byte_ext;

  // byte offset is below 256, so one conditional subtract gives the modulo
  assign byte_ext = {1'b0, req.byte_addr};
  assign idx = (byte_ext >= 9'(RAM_DEPTH)) ? IdxW'(byte_ext - 9'(RAM_DEPTH))
                                           : IdxW'(byte_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == IdxW'(RAM_DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt] <= '0;
    end else if (req.wr) begin
      mem[idx] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      rd_data <= mem[idx];
    end
  end

endmodule

// ===== rtl/cbm_checker.sv =====
// ----------------------------------------------------------------------------
// cbm_checker
// Port-level checks for the cartridge bank mapper.
// ----------------------------------------------------------------------------
module cbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [13:0] rom_offset,
  input logic        from_ram,
  input logic [7:0]  ram_data,
  input logic        ram_written,
  input logic [1:0]  active_bank
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rom_offset) && $stable(ram_data)
      && $stable(active_bank))
    else $error("result changed while stalled");

  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_ram_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !from_ram |-> ram_data == 8'd0)
    else $error("ram_data nonzero without RAM read");

  a_rd_wr_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(from_ram && ram_written))
    else $error("RAM read and write on one access");

  a_bank_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rom_offset[13:12] == active_bank)
    else $error("rom_offset bank bits disagree with active_bank");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .rom_offset  (rom_offset),
  .from_ram    (from_ram),
  .ram_data    (ram_data),
  .ram_written (ram_written),
  .active_bank (active_bank)
);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cartridge bank mapper. It runs directed bus
// accesses, then random phases under random image size and RAM settings,
// with random gaps on both handshakes. Every result is checked against an
// in-bench model of the banking, mirroring and extra RAM.
// ----------------------------------------------------------------------------
module tb_top import cbm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;
  // index with no register behind it
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic [13:0] rom_offset;
    logic        from_ram;
    logic [7:0]  ram_data;
    logic        ram_written;
    logic [1:0]  active_bank;
  } map_result_t;

  class mapper_scoreboard;
    logic [1:0]  rom_size;
    logic [1:0]  ram_mode;
    logic [1:0]  bank_sel;
    logic [7:0]  ram_copy [256];
    map_result_t pending_maps [$];
    int          failures;

    function new();
      rom_size = ROM_4K;
      ram_mode = RAM_NONE;
      bank_sel = 2'd0;
      failures = 0;
      foreach (ram_copy[i]) ram_copy[i] = 8'h00;
    endfunction

    function void set_reg(logic [1:0] idx, logic [1:0] val);
      if (idx == CFG_ROM_SIZE) rom_size = val;
      else if (idx == CFG_RAM_MODE) ram_mode = val;
    endfunction

    function int pending();
      return pending_maps.size();
    endfunction

    // bank switch happens before the access is served
    function void note_access(logic f, logic [11:0] a, logic [7:0] d);
      logic [11:0] off;
      logic [11:0] span;
      logic [1:0]  bank;
      map_result_t r;
      off = a;
      if (rom_size == ROM_2K && off >= MIRROR_BASE) off = off - MIRROR_BASE;
      if (rom_size == ROM_F8) begin
        if (off == HOT_F8_B0) bank_sel = 2'd0;
        else if (off == HOT_F8_B1) bank_sel = 2'd1;
      end else if (rom_size == ROM_F6 && off >= HOT_F6_LO && off <= HOT_F8_B1) begin
        bank_sel = 2'(off - HOT_F6_LO);
      end
      case (rom_size)
        ROM_F8:  bank = {1'b0, bank_sel[0]};
        ROM_F6:  bank = bank_sel;
        default: bank = 2'd0;
      endcase
      span = (ram_mode == RAM_128) ? SPAN_128 : (ram_mode == RAM_256) ? SPAN_256 : 12'd0;
      r.rom_offset  = {bank, off};
      r.from_ram    = 1'b0;
      r.ram_data    = 8'h00;
      r.ram_written = 1'b0;
      r.active_bank = bank;
      if (span != 12'd0) begin
        if (f == ACC_WRITE) begin
          if (off < span) begin
            ram_copy[off[7:0]] = d;
            r.ram_written = 1'b1;
          end
        end else if (off >= span && off < 2 * span) begin
          r.from_ram = 1'b1;
          r.ram_data = ram_copy[8'(off - span)];
        end
      end
      pending_maps.push_back(r);
    endfunction

    function void check_result(logic [13:0] offs, logic fr, logic [7:0] rd, logic wr,
                               logic [1:0] bk);
      map_result_t e;
      if (pending_maps.size() == 0) begin
        $error("result transaction with nothing expected");
        failures++;
        return;
      end
      e = pending_maps.pop_front();
      if (offs !== e.rom_offset) begin
        $error("rom_offset expected %h got %h", e.rom_offset, offs);
        failures++;
      end
      if (fr !== e.from_ram) begin
        $error("from_ram expected %b got %b", e.from_ram, fr);
        failures++;
      end
      if (rd !== e.ram_data) begin
        $error("ram_data expected %h got %h", e.ram_data, rd);
        failures++;
      end
      if (wr !== e.ram_written) begin
        $error("ram_written expected %b got %b", e.ram_written, wr);
        failures++;
      end
      if (bk !== e.active_bank) begin
        $error("active_bank expected %h got %h", e.active_bank, bk);
        failures++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [1:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        func;
  logic [11:0] address;
  logic [7:0]  write_data;
  logic        out_valid;
  logic        out_ready;
  logic [13:0] rom_offset;
  logic        from_ram;
  logic [7:0]  ram_data;
  logic        ram_written;
  logic [1:0]  active_bank;

  mapper_scoreboard sb;
  bit steady;

  cartridge_bank_mapper dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .address    (address),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rom_offset (rom_offset),
    .from_ram   (from_ram),
    .ram_data   (ram_data),
    .ram_written(ram_written),
    .active_bank(active_bank)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // weighted toward hotspots, the RAM ports and the mirror boundary
  function automatic logic [11:0] pick_address();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 12'hFF0 + 12'($urandom_range(0, 15));
    if (r < 65) return 12'($urandom_range(0, 511));
    if (r < 75) return MIRROR_BASE - 12'd16 + 12'($urandom_range(0, 31));
    return 12'($urandom);
  endfunction

  initial begin
    int gap;
    out_ready = 1'b0;
    gap = 0;
    forever begin
      @(negedge clk);
      if (gap > 0) begin
        out_ready = 1'b0;
        gap--;
      end else begin
        out_ready = 1'b1;
        gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_access(func, address, write_data);
      if (out_valid && out_ready)
        sb.check_result(rom_offset, from_ram, ram_data, ram_written, active_bank);
    end
  end

  task automatic send_access(input logic f, input logic [11:0] a, input logic [7:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   = 1'b1;
    func       = f;
    address    = a;
    write_data = d;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold off new accesses until every outstanding result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [1:0] rs;
    logic [1:0] rm;
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_ROM_SIZE;
    cfg_data   = 2'd0;
    in_valid   = 1'b0;
    func       = ACC_READ;
    address    = 12'h000;
    write_data = 8'h00;
    steady     = 1'b0;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset config: 4K image, no RAM; ROM writes are dropped
    send_access(ACC_READ, 12'h000, 8'h00);
    send_access(ACC_READ, 12'hFFF, 8'h00);
    send_access(ACC_WRITE, 12'hFFF, 8'hFF);
    send_access(ACC_READ, 12'h100, 8'h00);
    drain_results();

    // F6 with 256 byte RAM: all four hotspots, both port edges
    write_reg(CFG_ROM_SIZE, ROM_F6);
    write_reg(CFG_RAM_MODE, RAM_256);
    send_access(ACC_READ, 12'hFF6, 8'h00);
    send_access(ACC_READ, 12'hFF7, 8'h00);
    send_access(ACC_READ, 12'hFF8, 8'h00);
    send_access(ACC_READ, 12'hFF9, 8'h00);
    send_access(ACC_WRITE, 12'h000, 8'hA5);
    send_access(ACC_WRITE, 12'h0FF, 8'h5A);
    send_access(ACC_READ, 12'h100, 8'h00);
    send_access(ACC_READ, 12'h1FF, 8'h00);
    send_access(ACC_READ, 12'h200, 8'h00);
    send_access(ACC_WRITE, 12'h100, 8'h3C);
    send_access(ACC_WRITE, 12'hFF7, 8'h77);
    drain_results();

    // F8 with 128 byte RAM; bank select carries over from F6
    write_reg(CFG_ROM_SIZE, ROM_F8);
    write_reg(CFG_RAM_MODE, RAM_128);
    send_access(ACC_READ, 12'hFF6, 8'h00);
    send_access(ACC_READ, 12'hFF9, 8'h00);
    send_access(ACC_WRITE, 12'h07F, 8'h81);
    send_access(ACC_READ, 12'h0FF, 8'h00);
    send_access(ACC_READ, 12'h080, 8'h00);
    send_access(ACC_WRITE, 12'hFF8, 8'h00);
    drain_results();

    // 2K mirror, unused RAM mode behaves as none
    write_reg(CFG_ROM_SIZE, ROM_2K);
    write_reg(CFG_RAM_MODE, 2'd3);
    send_access(ACC_READ, 12'h7FF, 8'h00);
    send_access(ACC_READ, 12'h800, 8'h00);
    send_access(ACC_WRITE, 12'h800, 8'h11);
    drain_results();

    // mirrored offset lands in the RAM read port
    write_reg(CFG_RAM_MODE, RAM_128);
    write_reg(CFG_SPARE, 2'd2);
    send_access(ACC_READ, 12'h880, 8'h00);
    send_access(ACC_WRITE, 12'h87F, 8'hC3);
    send_access(ACC_READ, 12'hFFF, 8'h00);
    drain_results();

    for (int ph = 0; ph < 12; ph++) begin
      rs = 2'($urandom_range(0, 3));
      rm = 2'($urandom_range(0, 3));
      write_reg(CFG_ROM_SIZE, rs);
      write_reg(CFG_RAM_MODE, rm);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, 2'($urandom));
      steady = (ph % 4 == 2);
      for (int i = 0; i < 100; i++) begin
        if (i == 50 && ph % 3 == 0) drain_results();
        send_access(1'($urandom), pick_address(), 8'($urandom));
      end
      drain_results();
    end
    steady = 1'b0;

    drain_results();
    repeat (6) @(posedge clk);
    if (sb.failures == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
